[design/smq_pkg.sv]
package smq_pkg;

  localparam logic OPC_BYTE = 1'b0;
  localparam logic OPC_TICK = 1'b1;

  localparam logic KIND_ECHO  = 1'b0;
  localparam logic KIND_DIGIT = 1'b1;

  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;

  localparam logic [7:0] CH_ALL_ON  = 8'h41;
  localparam logic [7:0] CH_ALL_OFF = 8'h53;
  localparam logic [7:0] CH_RESUME  = 8'h50;
  localparam logic [7:0] CH_PAUSE   = 8'h4f;
  localparam logic [7:0] CH_FASTER  = 8'h46;
  localparam logic [7:0] CH_SLOWER  = 8'h57;
  localparam logic [7:0] CH_LEFT    = 8'h4c;
  localparam logic [7:0] CH_RIGHT   = 8'h52;

  localparam logic [7:0] FILL_ON  = 8'hff;
  localparam logic [7:0] FILL_OFF = 8'h00;

  localparam logic [15:0] PERIOD_RESET = 16'd100;
  localparam logic [15:0] PERIOD_STEP  = 16'd10;
  localparam logic [15:0] PERIOD_MAX   = 16'd65530;

  localparam int INIT_LEN = 8;
  localparam logic [7:0] RING_INIT [INIT_LEN] = '{
    8'h67, 8'h06, 8'h5b, 8'h06, 8'h4e, 8'h3e, 8'h0f, 8'h4f
  };

  typedef enum logic [1:0] {
    OP_NONE,
    OP_FILL,
    OP_SCROLL
  } op_e;

  typedef struct packed {
    logic       has_echo;
    logic [7:0] echo_byte;
    op_e        op;
    logic [7:0] fill_byte;
    logic       dir_left;
  } cmd_t;

endpackage

[design/smq_front.sv]
module smq_front import smq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       in_opcode_i,
  input  logic [7:0] in_rx_byte_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic        paused_q, paused_d;
  logic [1:0]  dir_q, dir_d;
  logic [15:0] period_q, period_d;
  logic [15:0] cd_q, cd_d;
  logic [15:0] cd_dec;
  logic [16:0] period_sum;
  logic        accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign period_sum = {1'b0, period_q} + {1'b0, PERIOD_STEP};

  always_comb begin
    paused_d = paused_q;
    dir_d    = dir_q;
    period_d = period_q;
    cd_d     = cd_q;
    cd_dec   = cd_q;
    push_o   = 1'b0;
    cmd_o    = '{has_echo: 1'b0, echo_byte: in_rx_byte_i, op: OP_NONE,
                 fill_byte: FILL_OFF, dir_left: 1'b0};
    if (accept) begin
      if (in_opcode_i == OPC_BYTE) begin
        push_o         = 1'b1;
        cmd_o.has_echo = 1'b1;
        unique case (in_rx_byte_i)
          CH_ALL_ON: begin
            paused_d        = 1'b1;
            cmd_o.op        = OP_FILL;
            cmd_o.fill_byte = FILL_ON;
          end
          CH_ALL_OFF: begin
            paused_d        = 1'b1;
            cmd_o.op        = OP_FILL;
            cmd_o.fill_byte = FILL_OFF;
          end
          CH_RESUME: paused_d = 1'b0;
          CH_PAUSE:  paused_d = 1'b1;
          CH_FASTER: begin
            if (period_q > PERIOD_STEP) begin
              period_d = period_q - PERIOD_STEP;
            end
          end
          CH_SLOWER: begin
            if (period_sum > {1'b0, PERIOD_MAX}) begin
              period_d = PERIOD_MAX;
            end else begin
              period_d = period_sum[15:0];
            end
          end
          CH_LEFT:  dir_d = DIR_LEFT;
          CH_RIGHT: dir_d = DIR_RIGHT;
          default: ;
        endcase
      end else if (!paused_q && (dir_q == DIR_LEFT || dir_q == DIR_RIGHT)) begin
        if (cd_q != '0) begin
          cd_dec = cd_q - 16'd1;
        end
        if (cd_dec == '0) begin
          push_o         = 1'b1;
          cmd_o.op       = OP_SCROLL;
          cmd_o.dir_left = (dir_q == DIR_LEFT);
          cd_d           = period_q;
        end else begin
          cd_d = cd_dec;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paused_q <= 1'b0;
      dir_q    <= DIR_NONE;
      period_q <= PERIOD_RESET;
      cd_q     <= '0;
    end else begin
      paused_q <= paused_d;
      dir_q    <= dir_d;
      period_q <= period_d;
      cd_q     <= cd_d;
    end
  end

endmodule

[design/smq_queue.sv]
module smq_queue import smq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth))
    else $error("queue count out of range");

endmodule

[design/smq_back.sv]
module smq_back import smq_pkg::*; #(
  parameter int RING_DEPTH     = 16,
  parameter int VISIBLE_DIGITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  cmd_t       q_cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_kind_o,
  output logic [3:0] out_digit_o,
  output logic [7:0] out_data_o,
  output logic       out_last_o
);

  localparam int IdxW  = (VISIBLE_DIGITS > 1) ? $clog2(VISIBLE_DIGITS) : 1;
  localparam int RingW = $clog2(RING_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(VISIBLE_DIGITS - 1);

  logic [7:0]      ring_q [RING_DEPTH];
  logic [7:0]      rot_left [RING_DEPTH];
  logic [7:0]      rot_right [RING_DEPTH];
  logic            busy_q, busy_d;
  logic            echo_q, echo_d;
  cmd_t            cmd_q, cmd_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q;
  logic            out_kind_q, out_last_q;
  logic [3:0]      out_digit_q;
  logic [7:0]      out_data_q;
  logic            adv, produce;
  logic            res_kind, res_last;
  logic [3:0]      res_digit;
  logic [7:0]      res_data;

  assign adv     = ~out_valid_q | ~out_stall_i;
  assign produce = adv & busy_q;
  assign pop_o   = ~busy_q & ~q_empty_i;

  always_comb begin
    for (int i = 0; i < RING_DEPTH - 1; i++) begin
      rot_left[i]      = ring_q[i+1];
      rot_right[i+1]   = ring_q[i];
    end
    rot_left[RING_DEPTH-1] = ring_q[0];
    rot_right[0]           = ring_q[RING_DEPTH-1];
  end

  always_comb begin
    if (echo_q) begin
      res_kind  = KIND_ECHO;
      res_digit = 4'd0;
      res_data  = cmd_q.echo_byte;
      res_last  = (cmd_q.op == OP_NONE);
    end else begin
      res_kind  = KIND_DIGIT;
      res_digit = 4'(VISIBLE_DIGITS) - 4'(idx_q);
      res_data  = (cmd_q.op == OP_FILL) ? cmd_q.fill_byte : ring_q[RingW'(idx_q)];
      res_last  = (idx_q == LastIdx);
    end
  end

  always_comb begin
    busy_d = busy_q;
    echo_d = echo_q;
    cmd_d  = cmd_q;
    idx_d  = idx_q;
    if (pop_o) begin
      busy_d = 1'b1;
      echo_d = q_cmd_i.has_echo;
      cmd_d  = q_cmd_i;
      idx_d  = '0;
    end else if (produce) begin
      if (echo_q) begin
        echo_d = 1'b0;
        if (cmd_q.op == OP_NONE) begin
          busy_d = 1'b0;
        end
      end else if (res_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= (i < INIT_LEN) ? RING_INIT[i % INIT_LEN] : 8'h00;
      end
    end else if (pop_o && q_cmd_i.op == OP_SCROLL) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= q_cmd_i.dir_left ? rot_left[i] : rot_right[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      echo_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      echo_q <= echo_d;
      idx_q  <= idx_d;
      if (adv) begin
        out_valid_q <= produce;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (produce) begin
      out_kind_q  <= res_kind;
      out_digit_q <= res_digit;
      out_data_q  <= res_data;
      out_last_q  <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_digit_o = out_digit_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !busy_q)
    else $error("queue popped while sequencer busy");

  a_digits_need_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !echo_q) |-> (cmd_q.op != OP_NONE))
    else $error("digit phase without digit operation");

  a_last_digit_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o == KIND_DIGIT && out_last_o) |-> (out_digit_o == 4'd1))
    else $error("final digit write not at digit one");

endmodule

[design/scrolling_digit_marquee_controller.sv]
// Marquee controller for an eight-digit seven-segment display. Each input item
// is a received command byte (echoed, then decoded) or a one-millisecond tick.
// A command yields its echo plus, for the fill commands, VISIBLE_DIGITS digit
// writes; a tick that steps the scroll yields VISIBLE_DIGITS digit writes, and
// other ticks yield nothing. An item's results leave one per cycle, while the
// output is not stalled, through a single output register; the output sequencer
// loads an item from the queue and takes the next only after the item's last
// result. A two-entry command queue lets input keep flowing while earlier
// results drain.
module scrolling_digit_marquee_controller import smq_pkg::*; #(
  parameter int RING_DEPTH     = 16,
  parameter int VISIBLE_DIGITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       in_opcode_i,
  input  logic [7:0] in_rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_kind_o,
  output logic [3:0] out_digit_o,
  output logic [7:0] out_data_o,
  output logic       out_last_o
);

  logic push, q_full, pop, q_empty;
  cmd_t push_cmd, pop_cmd;

  smq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_opcode_i (in_opcode_i),
    .in_rx_byte_i(in_rx_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  smq_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .cmd_o  (pop_cmd)
  );

  smq_back #(
    .RING_DEPTH    (RING_DEPTH),
    .VISIBLE_DIGITS(VISIBLE_DIGITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_cmd_i    (pop_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_kind_o (out_kind_o),
    .out_digit_o(out_digit_o),
    .out_data_o (out_data_o),
    .out_last_o (out_last_o)
  );

endmodule

[tb/testbench.sv]
module testbench;
  import smq_pkg::*;

  localparam int RING_LEN = 16;
  localparam int VISIBLE = 8;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SCRIPT_LEN = 25;
  localparam int PHASE_ITEMS = 65;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic       kind;
    logic [3:0] digit;
    logic [7:0] data;
    logic       last;
  } digit_write_t;

  typedef struct packed {
    logic       opc;
    logic [7:0] chr;
    logic       typed;
    logic [3:0] n_writes;
    logic [7:0] last_data;
  } script_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_opcode_i = OPC_BYTE;
  logic [7:0] in_rx_byte_i = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       out_kind_o;
  logic [3:0] out_digit_o;
  logic [7:0] out_data_o;
  logic       out_last_o;

  logic [7:0]  ring_q [RING_LEN];
  logic        paused_q;
  logic [1:0]  dir_q;
  logic [15:0] period_q;
  logic [15:0] countdown_q;
  int          scroll_steps = 0;

  digit_write_t pending_writes [$];
  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  script_row_t script [SCRIPT_LEN] = '{
    '{OPC_TICK, 8'h00,      1'b1, 4'd0, 8'h00},
    '{OPC_BYTE, 8'h00,      1'b1, 4'd1, 8'h00},
    '{OPC_BYTE, 8'hff,      1'b1, 4'd1, 8'hff},
    '{OPC_BYTE, CH_RIGHT,   1'b1, 4'd1, CH_RIGHT},
    '{OPC_TICK, 8'hff,      1'b1, 4'd8, 8'h0f},
    '{OPC_BYTE, CH_LEFT,    1'b0, 4'd0, 8'h00},
    '{OPC_TICK, 8'h5a,      1'b1, 4'd0, 8'h00},
    '{OPC_BYTE, CH_PAUSE,   1'b0, 4'd0, 8'h00},
    '{OPC_TICK, 8'ha5,      1'b1, 4'd0, 8'h00},
    '{OPC_BYTE, CH_RESUME,  1'b0, 4'd0, 8'h00},
    '{OPC_BYTE, CH_ALL_ON,  1'b1, 4'd9, FILL_ON},
    '{OPC_TICK, 8'h00,      1'b1, 4'd0, 8'h00},
    '{OPC_BYTE, CH_ALL_OFF, 1'b1, 4'd9, FILL_OFF},
    '{OPC_BYTE, CH_RESUME,  1'b0, 4'd0, 8'h00},
    '{OPC_BYTE, CH_SLOWER,  1'b0, 4'd0, 8'h00},
    '{OPC_BYTE, CH_FASTER,  1'b0, 4'd0, 8'h00},
    '{OPC_BYTE, CH_FASTER,  1'b0, 4'd0, 8'h00},
    '{OPC_BYTE, CH_FASTER,  1'b0, 4'd0, 8'h00},
    '{OPC_BYTE, CH_FASTER,  1'b0, 4'd0, 8'h00},
    '{OPC_BYTE, CH_FASTER,  1'b0, 4'd0, 8'h00},
    '{OPC_BYTE, CH_FASTER,  1'b0, 4'd0, 8'h00},
    '{OPC_BYTE, CH_FASTER,  1'b0, 4'd0, 8'h00},
    '{OPC_BYTE, CH_FASTER,  1'b0, 4'd0, 8'h00},
    '{OPC_BYTE, CH_FASTER,  1'b0, 4'd0, 8'h00},
    '{OPC_BYTE, CH_FASTER,  1'b0, 4'd0, 8'h00}
  };

  logic [7:0] cmd_pool [12] = '{
    CH_RESUME, CH_RESUME, CH_RESUME, CH_FASTER, CH_FASTER, CH_FASTER,
    CH_LEFT, CH_RIGHT, CH_SLOWER, CH_PAUSE, CH_ALL_ON, CH_ALL_OFF
  };

  int idle_by_phase [4] = '{0, 68, 0, 9};
  int stall_by_phase [4] = '{0, 0, 68, 9};

  scrolling_digit_marquee_controller #(
    .RING_DEPTH    (RING_LEN),
    .VISIBLE_DIGITS(VISIBLE)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_opcode_i (in_opcode_i),
    .in_rx_byte_i(in_rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_kind_o  (out_kind_o),
    .out_digit_o (out_digit_o),
    .out_data_o  (out_data_o),
    .out_last_o  (out_last_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int advance_marquee(input logic opc, input logic [7:0] chr);
    digit_write_t w;
    logic [7:0] spill;
    logic fill;
    logic [7:0] fill_byte;
    int n_before;
    n_before = pending_writes.size();
    fill = 1'b0;
    fill_byte = FILL_OFF;
    if (opc == OPC_BYTE) begin
      w = '{KIND_ECHO, 4'd0, chr, 1'b0};
      pending_writes.push_back(w);
      case (chr)
        CH_ALL_ON: begin
          paused_q = 1'b1;
          fill = 1'b1;
          fill_byte = FILL_ON;
        end
        CH_ALL_OFF: begin
          paused_q = 1'b1;
          fill = 1'b1;
          fill_byte = FILL_OFF;
        end
        CH_RESUME: paused_q = 1'b0;
        CH_PAUSE: paused_q = 1'b1;
        CH_FASTER: begin
          if (period_q > PERIOD_STEP) period_q = period_q - PERIOD_STEP;
        end
        CH_SLOWER: begin
          if (period_q > PERIOD_MAX - PERIOD_STEP) begin
            period_q = PERIOD_MAX;
          end else begin
            period_q = period_q + PERIOD_STEP;
          end
        end
        CH_LEFT: dir_q = DIR_LEFT;
        CH_RIGHT: dir_q = DIR_RIGHT;
        default: ;
      endcase
      if (fill) begin
        for (int i = 0; i < VISIBLE; i++) begin
          w = '{KIND_DIGIT, 4'(VISIBLE - i), fill_byte, 1'b0};
          pending_writes.push_back(w);
        end
      end
    end else if (!paused_q && (dir_q == DIR_LEFT || dir_q == DIR_RIGHT)) begin
      if (countdown_q != 16'd0) countdown_q = countdown_q - 16'd1;
      if (countdown_q == 16'd0) begin
        if (dir_q == DIR_LEFT) begin
          spill = ring_q[0];
          for (int i = 0; i < RING_LEN - 1; i++) ring_q[i] = ring_q[i + 1];
          ring_q[RING_LEN - 1] = spill;
        end else begin
          spill = ring_q[RING_LEN - 1];
          for (int i = RING_LEN - 1; i > 0; i--) ring_q[i] = ring_q[i - 1];
          ring_q[0] = spill;
        end
        for (int i = 0; i < VISIBLE; i++) begin
          w = '{KIND_DIGIT, 4'(VISIBLE - i), ring_q[i], 1'b0};
          pending_writes.push_back(w);
        end
        countdown_q = period_q;
        scroll_steps++;
      end
    end
    if (pending_writes.size() > n_before) begin
      w = pending_writes.pop_back();
      w.last = 1'b1;
      pending_writes.push_back(w);
    end
    return pending_writes.size() - n_before;
  endfunction

  task automatic send_item(input logic opc, input logic [7:0] chr, output int added);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_opcode_i <= opc;
    in_rx_byte_i <= chr;
    do @(posedge clk_i); while (in_stall_o);
    added = advance_marquee(opc, chr);
  endtask

  task automatic drain_writes();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_writes.size() != 0);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    digit_write_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected write: kind %0d digit %0d data %h last %0d",
                   out_kind_o, out_digit_o, out_data_o, out_last_o);
        end
      end else begin
        want = pending_writes.pop_front();
        if (out_kind_o !== want.kind || out_digit_o !== want.digit ||
            out_data_o !== want.data || out_last_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("write mismatch: expected kind %0d digit %0d data %h last %0d",
                     want.kind, want.digit, want.data, want.last);
            $display("                actual   kind %0d digit %0d data %h last %0d",
                     out_kind_o, out_digit_o, out_data_o, out_last_o);
          end
        end
      end
    end
  end

  initial begin
    int added;
    int target;
    logic opc;
    logic [7:0] chr;
    for (int i = 0; i < RING_LEN; i++) ring_q[i] = (i < INIT_LEN) ? RING_INIT[i] : 8'h00;
    paused_q = 1'b0;
    dir_q = DIR_NONE;
    period_q = PERIOD_RESET;
    countdown_q = 16'd0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_item(script[i].opc, script[i].chr, added);
      if (script[i].typed && (added != int'(script[i].n_writes) || (added > 0 &&
          pending_writes[pending_writes.size() - 1].data != script[i].last_data))) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("row %0d: %0d writes predicted, %0d typed", i, added, script[i].n_writes);
        end
      end
    end
    drain_writes();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 62) begin
          opc = OPC_TICK;
          chr = 8'($urandom_range(255));
        end else begin
          opc = OPC_BYTE;
          if ($urandom_range(3) == 0) begin
            chr = 8'($urandom_range(255));
          end else begin
            chr = cmd_pool[$urandom_range(11)];
          end
        end
        send_item(opc, chr, added);
      end
      drain_writes();
    end

    // run the step period down to its floor, then time two scroll steps at it
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (period_q > PERIOD_STEP) send_item(OPC_BYTE, CH_FASTER, added);
    send_item(OPC_BYTE, CH_FASTER, added);
    send_item(OPC_BYTE, CH_RESUME, added);
    send_item(OPC_BYTE, CH_LEFT, added);
    target = scroll_steps + 2;
    while (scroll_steps < target) send_item(OPC_TICK, 8'($urandom_range(255)), added);
    send_item(OPC_BYTE, CH_SLOWER, added);
    send_item(OPC_BYTE, CH_RIGHT, added);

    drain_writes();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
